// ----- hw/rtl/size_class_block_allocator_macros.svh -----
// Assertion helpers shared by the allocator modules.
// Every check is clocked on clk_i and held off while rst_ni is low.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SCBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define SCBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/scba_pkg.sv -----
package scba_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W   = 18;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned CLS_W    = 4;
  localparam int unsigned CHUNKS_W = 5;
  localparam int unsigned STAT_W   = 2;

  // Link store is indexed by 16-byte granule
  localparam int unsigned GRAN_SHIFT = 4;
  localparam int unsigned GRAN_BYTES = 1 << GRAN_SHIFT;
  localparam int unsigned GRAN_W     = ADDR_W - GRAN_SHIFT;
  localparam int unsigned LINK_DEPTH = 1 << GRAN_W;

  // Block classes
  localparam int unsigned NUM_CLASSES = 14;
  localparam int unsigned BYTES_W     = 10;
  localparam logic [BYTES_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
    10'd16,  10'd32,  10'd64,  10'd96,  10'd128, 10'd160, 10'd192,
    10'd224, 10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd640
  };

  // Parameter defaults
  localparam int unsigned CHUNK_BYTES_DEF     = 16384;
  localparam int unsigned NUM_CHUNKS_DEF      = 16;
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 640;
  localparam int unsigned CLASS_COUNT_DEF     = 14;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERSIZE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   block_addr;
    logic [STAT_W-1:0]   status;
    logic [CLS_W-1:0]    size_class;
    logic [CHUNKS_W-1:0] chunks_used;
  } rsp_t;

  // Free list link: empty flag over a granule index
  typedef struct packed {
    logic              empty;
    logic [GRAN_W-1:0] gran;
  } link_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the request
    logic exec;      // decide and commit, or start a list pop
    logic pop_done;  // finish a list pop with the read link
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_pop;  // request pops a nonempty free list
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

// ----- hw/rtl/scba_chan_if.sv -----
interface scba_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/scba_ctrl.sv -----
module scba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  scba_pkg::sts_t  sts_i,
  output scba_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0] state_q, state_d;

  // Sequence one request: capture, execute, optional list pop
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.need_pop ? ST_POP : ST_IDLE;
        end
      end
      ST_POP: begin
        if (sts_i.out_free) begin
          cmd_o.pop_done = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`include "size_class_block_allocator_macros.svh"

  `SCBA_ASSERT_NEXT(a_pop_follows_read, cmd_o.exec && sts_i.need_pop, state_q == ST_POP, "pop did not follow link read")
  `SCBA_ASSERT(a_one_cmd, $onehot0({cmd_o.load, cmd_o.exec, cmd_o.pop_done}), "more than one command")

endmodule

// ----- hw/rtl/scba_dp.sv -----
module scba_dp #(
  parameter int unsigned CHUNK_BYTES     = scba_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned NUM_CHUNKS      = scba_pkg::NUM_CHUNKS_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = scba_pkg::MAX_BLOCK_BYTES_DEF,
  parameter int unsigned CLASS_COUNT     = scba_pkg::CLASS_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scba_pkg::cmd_t  cmd_i,
  output scba_pkg::sts_t  sts_o,
  input  scba_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output scba_pkg::rsp_t  rsp_o
);

  localparam int unsigned ADDR_W = scba_pkg::ADDR_W;
  localparam int unsigned CLS_W  = scba_pkg::CLS_W;
  localparam int unsigned NCLS   = scba_pkg::NUM_CLASSES;
  localparam int unsigned LEFT_W = $clog2(CHUNK_BYTES / scba_pkg::GRAN_BYTES);
  localparam int unsigned CNT_W  = $clog2(NUM_CHUNKS + 1);

  localparam logic [ADDR_W-1:0] CHUNK_STEP = ADDR_W'(CHUNK_BYTES);

  // Blocks left after the first one of a fresh chunk, per class
  localparam logic [LEFT_W-1:0] CARVE_LAST [NCLS] = '{
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[0] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[1] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[2] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[3] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[4] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[5] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[6] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[7] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[8] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[9] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[10] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[11] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[12] - 1),
    LEFT_W'(CHUNK_BYTES / scba_pkg::CLASS_BYTES[13] - 1)
  };

  // Request registers
  scba_pkg::req_t req_q;

  // Class state
  scba_pkg::link_t   head_q [NCLS];
  logic [LEFT_W-1:0] left_q [NCLS];
  logic [ADDR_W-1:0] next_q [NCLS];
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] base_q;

  // Pending pop
  logic [CLS_W-1:0]               pop_cls_q;
  logic [scba_pkg::GRAN_W-1:0]    pop_gran_q;

  // Link store
  scba_pkg::link_t link_mem [scba_pkg::LINK_DEPTH];
  scba_pkg::link_t link_rdata_q;

  // Result register
  logic           rsp_valid_q;
  scba_pkg::rsp_t rsp_q;

  // Size mapping
  logic [NCLS-1:0] fits;
  logic [CLS_W-1:0] cls_sel;
  logic oversize;

  // Decision
  scba_pkg::link_t             head_sel;
  logic [LEFT_W-1:0]           left_sel;
  logic [ADDR_W-1:0]           next_sel;
  logic [ADDR_W-1:0]           bytes_sel;
  logic                        is_free;
  logic                        need_pop;
  logic                        do_carve;
  logic                        do_claim;
  logic [CNT_W-1:0]            cnt_nxt;
  logic [scba_pkg::GRAN_W-1:0] free_gran;
  scba_pkg::rsp_t              res_exec;
  scba_pkg::rsp_t              res_pop;

  // Map size to the smallest class that holds it
  always_comb begin
    cls_sel = '0;
    for (int i = 0; i < NCLS; i++) begin
      fits[i] = (i < CLASS_COUNT) &&
                (req_q.req_size <= scba_pkg::SIZE_W'(scba_pkg::CLASS_BYTES[i]));
    end
    for (int i = NCLS - 1; i >= 0; i--) begin
      if (fits[i]) begin
        cls_sel = CLS_W'(i);
      end
    end
    oversize = (req_q.req_size > scba_pkg::SIZE_W'(MAX_BLOCK_BYTES)) || !(|fits);
  end

  // Pick the action for the mapped class
  always_comb begin
    head_sel  = head_q[cls_sel];
    left_sel  = left_q[cls_sel];
    next_sel  = next_q[cls_sel];
    bytes_sel = ADDR_W'(scba_pkg::CLASS_BYTES[cls_sel]);
    free_gran = req_q.free_addr[ADDR_W-1:scba_pkg::GRAN_SHIFT];
    is_free   = (req_q.req_type == scba_pkg::REQ_FREE);
    need_pop  = !oversize && !is_free && !head_sel.empty;
    do_carve  = !oversize && !is_free && head_sel.empty && (left_sel != '0);
    do_claim  = !oversize && !is_free && head_sel.empty && (left_sel == '0) &&
                (cnt_q < CNT_W'(NUM_CHUNKS));
    cnt_nxt   = do_claim ? cnt_q + CNT_W'(1) : cnt_q;

    res_exec             = '0;
    res_exec.size_class  = oversize ? '0 : cls_sel;
    res_exec.chunks_used = scba_pkg::CHUNKS_W'(cnt_nxt);
    priority if (oversize) begin
      res_exec.status = scba_pkg::STAT_OVERSIZE;
    end else if (is_free) begin
      res_exec.status = scba_pkg::STAT_OK;
    end else if (do_carve) begin
      res_exec.block_addr = next_sel;
      res_exec.status     = scba_pkg::STAT_OK;
    end else if (do_claim) begin
      res_exec.block_addr = base_q;
      res_exec.status     = scba_pkg::STAT_OK;
    end else begin
      res_exec.status = scba_pkg::STAT_EXHAUSTED;
    end

    res_pop             = '0;
    res_pop.block_addr  = {pop_gran_q, scba_pkg::GRAN_SHIFT'(0)};
    res_pop.status      = scba_pkg::STAT_OK;
    res_pop.size_class  = pop_cls_q;
    res_pop.chunks_used = scba_pkg::CHUNKS_W'(cnt_q);
  end

  // Capture request and pop context, and advance the carve pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec && need_pop) begin
      pop_cls_q  <= cls_sel;
      pop_gran_q <= head_sel.gran;
    end
    if (cmd_i.exec && do_carve) begin
      next_q[cls_sel] <= next_sel + bytes_sel;
    end
    if (cmd_i.exec && do_claim) begin
      next_q[cls_sel] <= base_q + bytes_sel;
    end
  end

  // Update list heads, carve counters and the chunk pool
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCLS; i++) begin
        head_q[i] <= '{empty: 1'b1, gran: '0};
        left_q[i] <= '0;
      end
      cnt_q  <= '0;
      base_q <= '0;
    end else begin
      if (cmd_i.exec && !oversize && is_free) begin
        head_q[cls_sel] <= '{empty: 1'b0, gran: free_gran};
      end
      if (cmd_i.exec && do_carve) begin
        left_q[cls_sel] <= left_sel - LEFT_W'(1);
      end
      if (cmd_i.exec && do_claim) begin
        left_q[cls_sel] <= CARVE_LAST[cls_sel];
        cnt_q           <= cnt_nxt;
        base_q          <= base_q + CHUNK_STEP;
      end
      if (cmd_i.pop_done) begin
        head_q[pop_cls_q] <= link_rdata_q;
      end
    end
  end

  // Link store: push writes the old head, pop reads the next link
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !oversize && is_free) begin
      link_mem[free_gran] <= head_sel;
    end
    if (cmd_i.exec && need_pop) begin
      link_rdata_q <= link_mem[head_sel.gran];
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !need_pop) begin
      rsp_q <= res_exec;
    end else if (cmd_i.pop_done) begin
      rsp_q <= res_pop;
    end
  end

  // Result valid: set on a finished request, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((cmd_i.exec && !need_pop) || cmd_i.pop_done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign sts_o.need_pop = need_pop;
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_o          = rsp_q;

`include "size_class_block_allocator_macros.svh"

  `SCBA_ASSERT(a_pool_bound, cnt_q <= CNT_W'(NUM_CHUNKS), "chunk count beyond pool")
  `SCBA_ASSERT(a_fail_no_addr, !rsp_valid_q || rsp_q.status == scba_pkg::STAT_OK || rsp_q.block_addr == '0, "failed request carries an address")
  `SCBA_ASSERT_NEXT(a_pop_has_link, cmd_i.exec && need_pop, !cmd_i.exec, "second execute during a pop")

endmodule

// ----- hw/rtl/size_class_block_allocator.sv -----
// Small-block allocator with one LIFO free list per size class. A request is
// an allocate or a free of a byte size; the size maps to the smallest of up to
// 14 classes (16 to 640 bytes). Allocate pops the class list, else carves the
// next block of the class's current chunk, else claims a fresh chunk from the
// pool; free pushes the block at its 16-byte granule, with no check of the
// address. Sizes above MAX_BLOCK_BYTES or the largest class report oversize,
// an empty pool reports exhaustion, and neither changes state. One result
// comes back per request. A request is captured on transfer and executed once
// the result register is free; an allocate served from a free list then adds
// a list pop, because the next-link lookup is one synchronous read of the link
// memory. The next request is taken only once the current one is finished.
// The link memory has no reset and needs no clearing: only links written by a
// free are ever read.
module size_class_block_allocator #(
  parameter int unsigned CHUNK_BYTES     = scba_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned NUM_CHUNKS      = scba_pkg::NUM_CHUNKS_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = scba_pkg::MAX_BLOCK_BYTES_DEF,
  parameter int unsigned CLASS_COUNT     = scba_pkg::CLASS_COUNT_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  scba_chan_if.sink   req_i,
  scba_chan_if.source rsp_o
);

  scba_pkg::cmd_t cmd;
  scba_pkg::sts_t sts;
  logic           req_ready;
  logic           rsp_valid;
  scba_pkg::rsp_t rsp_data;

  // Sequence each request
  scba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Class state, link memory and result register
  scba_dp #(
    .CHUNK_BYTES     (CHUNK_BYTES),
    .NUM_CHUNKS      (NUM_CHUNKS),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .CLASS_COUNT     (CLASS_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i.data),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

endmodule
